// File: rtl/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

  // Widest frame the line memory can hold.
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  // Holds a row width up to MaxWidth itself.
  localparam int unsigned WidW     = ColW + 1;
  // Input rows run one past the frame height while flushes drain it.
  localparam int unsigned RowW     = 17;
  // Sum of nine 8-bit channel values.
  localparam int unsigned SumW     = 12;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);

  // Request opcodes.
  localparam logic OpPush  = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One entry of the line memory: two rows back and one row back.
  typedef struct packed {
    pixel_t prev2;
    pixel_t prev;
  } line_pair_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_last;
  } out_item_t;

  // Window sums and the number of in-frame rows and columns behind them.
  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
    logic [1:0]      rows;
    logic [1:0]      cols;
  } sum_item_t;

endpackage

`default_nettype wire

// File: rtl/bb3_line_buf.sv
`default_nettype none

module bb3_line_buf import bb3_pkg::*; (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [ColW-1:0]  rd_addr_i,
  output line_pair_t       rd_data_o,
  input  logic             wr_en_i,
  input  logic [ColW-1:0]  wr_addr_i,
  input  line_pair_t       wr_data_i
);

  // Both line buffers share one entry per column.
  line_pair_t mem_q [MaxWidth];
  line_pair_t rd_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// File: rtl/bb3_mean.sv
`default_nettype none

module bb3_mean import bb3_pkg::*; (
  input  sum_item_t sum_i,
  output pixel_t    mean_o
);

  // Reciprocal of the pixel count scaled by 2^16. The products stay exact
  // for every rounded sum below 4096.
  function automatic logic [16:0] recip(input logic [3:0] n);
    logic [16:0] m;
    case (n)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Rounds half up: floor((sum + floor(n/2)) / n).
  function automatic logic [7:0] div_round(input logic [SumW-1:0] sum,
                                           input logic [3:0]      n,
                                           input logic [16:0]     m);
    logic [SumW-1:0] y;
    logic [SumW+16:0] prod;
    y    = sum + SumW'(n >> 1);
    prod = (SumW + 17)'(y) * (SumW + 17)'(m);
    return prod[16 +: 8];
  endfunction

  logic [3:0]  count;
  logic [16:0] mult;

  assign count = 4'(sum_i.rows) * 4'(sum_i.cols);
  assign mult  = recip(count);

  assign mean_o.red   = div_round(sum_i.red,   count, mult);
  assign mean_o.green = div_round(sum_i.green, count, mult);
  assign mean_o.blue  = div_round(sum_i.blue,  count, mult);

endmodule

`default_nettype wire

// File: rtl/box_blur_3x3_edge_aware_unit.sv
// 3x3 box blur of an RGB raster stream. Each result is the mean of the
// in-frame pixels of the 3x3 neighborhood, rounded half up per channel.
// Frame width (1 to 1024, 0 acts as 1) and height (0 acts as 1) are set
// through the configuration port while the unit is idle; a write restarts
// the frame. A result leaves image_width+1 requests after its pixel; after
// the last pixel, send one flush request per outstanding result. Pushes
// after the last pixel and flushes during the frame are taken and dropped.
// Each request not dropped reads the line memory entry of its column, then
// writes it back and shifts the window; the input waits for the write-back,
// but not for a dropped request. Sums are registered and the rounded mean
// goes to an output register, so one result can wait at the output without
// holding up new requests; a second pending result stalls the input until
// the output is taken. The line memory needs no clearing pass.
`default_nettype none

module box_blur_3x3_edge_aware_unit import bb3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [10:0] cfg_width_q;
  logic [15:0] cfg_height_q;
  logic [WidW-1:0] eff_w;
  logic [15:0]     eff_h;
  logic [ColW-1:0] w_last;

  // Input position.
  logic [RowW-1:0] in_row_q, in_row_d;
  logic [ColW-1:0] in_col_q, in_col_d;

  // Read stage.
  logic            s1_valid_q;
  pixel_t          s1_pix_q;
  logic [ColW-1:0] s1_addr_q;
  logic            s1_emit_q;
  logic            s1_last_q;
  logic [2:0]      s1_row_ok_q;
  logic [2:0]      s1_col_ok_q;

  // Sum stage.
  logic      s2_valid_q;
  sum_item_t s2_q;
  logic      s2_last_q;
  logic      s2_move;

  // Output register.
  logic      out_valid_q;
  out_item_t out_q;

  logic       cfg_write;
  logic       in_fire;
  logic       input_done;
  logic       match;
  logic [RowW-1:0] row_off;
  logic [RowW-1:0] cr;
  logic [ColW-1:0] cc;
  logic       emit;
  logic       last;
  logic [2:0] row_ok;
  logic [2:0] col_ok;

  line_pair_t rd_data;
  line_pair_t wr_data;
  pixel_t     win_q [3][3];
  pixel_t     win_d [3][3];
  sum_item_t  sum_d;
  pixel_t     mean;

  // Effective frame size.
  always_comb begin
    if (cfg_width_q == '0) begin
      eff_w = WidW'(1);
    end else if (32'(cfg_width_q) > MaxWidth) begin
      eff_w = WidW'(MaxWidth);
    end else begin
      eff_w = WidW'(cfg_width_q);
    end
    eff_h = (cfg_height_q == '0) ? 16'd1 : cfg_height_q;
  end

  assign w_last = ColW'(eff_w - WidW'(1));

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o &&
                       ((cfg_index_i == CfgImageWidth) || (cfg_index_i == CfgImageHeight));

  assign s2_move    = s2_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q && (!s2_valid_q || s2_move);
  assign in_fire    = in_valid_i && in_ready_o;

  // A push is used while the frame is incoming, a flush only after it.
  assign input_done = in_row_q >= RowW'(eff_h);
  assign match      = (in_data_i.opcode == OpFlush) == input_done;

  // Window center after this request shifts in.
  always_comb begin
    if (in_col_q != '0) begin
      row_off = RowW'(1);
      cc      = in_col_q - ColW'(1);
    end else begin
      row_off = RowW'(2);
      cc      = w_last;
    end
    cr     = in_row_q - row_off;
    emit   = (in_row_q >= row_off) && (cr < RowW'(eff_h));
    last   = emit && (cr == RowW'(eff_h - 16'd1)) && (cc == w_last);
    row_ok = {cr != RowW'(eff_h - 16'd1), 1'b1, cr != '0};
    col_ok = {cc != w_last, 1'b1, cc != '0};
  end

  // Next input position; a register write or the frame's last result restarts it.
  always_comb begin
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    if (cfg_write) begin
      in_row_d = '0;
      in_col_d = '0;
    end else if (in_fire && match) begin
      if (last) begin
        in_row_d = '0;
        in_col_d = '0;
      end else if (WidW'(in_col_q) + WidW'(1) >= eff_w) begin
        in_row_d = in_row_q + RowW'(1);
        in_col_d = '0;
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
    end
  end

  // Configuration and position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= 11'd1024;
      cfg_height_q <= 16'd1;
      in_row_q     <= '0;
      in_col_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CfgImageWidth)) begin
        cfg_width_q <= cfg_data_i[10:0];
      end
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CfgImageHeight)) begin
        cfg_height_q <= cfg_data_i;
      end
      in_row_q <= in_row_d;
      in_col_q <= in_col_d;
    end
  end

  // Read stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire && match && !cfg_write;
    end
  end

  // Read stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire && match) begin
      s1_pix_q    <= (in_data_i.opcode == OpFlush) ? '0 :
                     {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
      s1_addr_q   <= in_col_q;
      s1_emit_q   <= emit;
      s1_last_q   <= last;
      s1_row_ok_q <= row_ok;
      s1_col_ok_q <= col_ok;
    end
  end

  // Line memory: read at accept, write back the shifted column in the next cycle.
  assign wr_data.prev2 = rd_data.prev;
  assign wr_data.prev  = s1_pix_q;

  bb3_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire && match),
    .rd_addr_i (in_col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data)
  );

  // Window shift and masked sums of the shifted window.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_d[r][c] = win_q[r][c];
      end
    end
    if (s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
      end
      win_d[0][2] = rd_data.prev2;
      win_d[1][2] = rd_data.prev;
      win_d[2][2] = s1_pix_q;
    end
    sum_d.red   = '0;
    sum_d.green = '0;
    sum_d.blue  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (s1_row_ok_q[r] && s1_col_ok_q[c]) begin
          sum_d.red   = sum_d.red   + SumW'(win_d[r][c].red);
          sum_d.green = sum_d.green + SumW'(win_d[r][c].green);
          sum_d.blue  = sum_d.blue  + SumW'(win_d[r][c].blue);
        end
      end
    end
    sum_d.rows = 2'(s1_row_ok_q[0]) + 2'(s1_row_ok_q[1]) + 2'(s1_row_ok_q[2]);
    sum_d.cols = 2'(s1_col_ok_q[0]) + 2'(s1_col_ok_q[1]) + 2'(s1_col_ok_q[2]);
  end

  // Window registers.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_q[r][c] <= win_d[r][c];
      end
    end
  end

  // Sum stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_emit_q) begin
      s2_valid_q <= 1'b1;
    end else if (s2_move) begin
      s2_valid_q <= 1'b0;
    end
  end

  // Sum stage payload.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_emit_q) begin
      s2_q      <= sum_d;
      s2_last_q <= s1_last_q;
    end
  end

  bb3_mean u_mean (
    .sum_i  (s2_q),
    .mean_o (mean)
  );

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_q <= {mean.red, mean.green, mean.blue, s2_last_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The read stage never holds two requests back to back.
  a_s1_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> !s1_valid_q)
    else $error("read stage occupied on consecutive cycles");

  // A new sum never lands on a sum still waiting.
  a_s2_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !s2_valid_q)
    else $error("sum stage overwritten");

  // A register write restarts the frame.
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> (in_row_q == '0) && (in_col_q == '0))
    else $error("position not cleared by register write");

  // The column stays inside the row.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WidW'(in_col_q) < eff_w)
    else $error("input column beyond row width");

  // Flushes never run past the row of the frame's last result.
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= RowW'(eff_h) + RowW'(1))
    else $error("input row beyond frame drain");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bb3_pkg::*;

  // Cycles allowed after the last expected result before the unit counts as idle.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RandItems    = 800;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Shadow copy of the unit's registers, line memory, window and frame position.
  logic [10:0]  frame_w_reg;
  logic [15:0]  frame_h_reg;
  pixel_t       row_above  [MaxWidth];
  pixel_t       row_above2 [MaxWidth];
  pixel_t       blur_win   [9];
  int unsigned  px_row;
  int unsigned  px_col;

  out_item_t    blur_q [$];
  int unsigned  err_cnt   = 0;
  int unsigned  taken_cnt = 0;
  bit           calm      = 1'b0;
  bit           rx_hold   = 1'b0;
  bit           rx_bursty = 1'b1;
  bit           tx_bursty = 1'b1;
  int unsigned  rx_stall  = 0;

  always #5 clk_i = ~clk_i;

  box_blur_3x3_edge_aware_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic int unsigned eff_w();
    if (frame_w_reg == 0) return 1;
    if (frame_w_reg > MaxWidth) return MaxWidth;
    return frame_w_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (frame_h_reg == 0) ? 1 : frame_h_reg;
  endfunction

  // Advances the shadow state by one request and queues the blurred pixel it releases.
  function automatic void blur_predict(in_item_t req);
    int unsigned w;
    int unsigned h;
    int          cr;
    int          cc;
    int          rr;
    int          cx;
    int          r;
    int          c;
    int          n;
    int          sum_r;
    int          sum_g;
    int          sum_b;
    bit          flush;
    pixel_t      pix;
    pixel_t      top;
    pixel_t      mid;
    pixel_t      v;
    out_item_t   res;
    w = eff_w();
    h = eff_h();
    flush = (req.opcode == OpFlush);
    // Pushes after the last pixel and flushes during the frame are dropped.
    if (flush != (px_row >= h)) return;
    taken_cnt++;
    pix = flush ? '0 : {req.in_red, req.in_green, req.in_blue};
    top = '0;
    mid = '0;
    if (px_col < MaxWidth) begin
      top = row_above2[px_col];
      mid = row_above[px_col];
      row_above2[px_col] = mid;
      row_above[px_col]  = pix;
    end
    for (r = 0; r < 3; r++) begin
      blur_win[r*3]   = blur_win[r*3+1];
      blur_win[r*3+1] = blur_win[r*3+2];
    end
    blur_win[2] = top;
    blur_win[5] = mid;
    blur_win[8] = pix;
    // The window center trails the incoming pixel by one row and one column.
    if (px_col >= 1) begin
      cr = int'(px_row) - 1;
      cc = int'(px_col) - 1;
    end else begin
      cr = int'(px_row) - 2;
      cc = int'(w) - 1;
    end
    px_col++;
    if (px_col >= w) begin
      px_col = 0;
      px_row++;
    end
    if (cr < 0 || cr >= int'(h)) return;
    n = 0;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (r = 0; r < 3; r++) begin
      rr = cr - 1 + r;
      if (rr < 0 || rr >= int'(h)) continue;
      for (c = 0; c < 3; c++) begin
        cx = cc - 1 + c;
        if (cx < 0 || cx >= int'(w)) continue;
        v = blur_win[r*3+c];
        sum_r += v.red;
        sum_g += v.green;
        sum_b += v.blue;
        n++;
      end
    end
    // Round half up on each channel.
    res.out_red   = 8'((2 * sum_r + n) / (2 * n));
    res.out_green = 8'((2 * sum_g + n) / (2 * n));
    res.out_blue  = 8'((2 * sum_b + n) / (2 * n));
    res.out_last  = (cr == int'(h) - 1) && (cc == int'(w) - 1);
    if (res.out_last) begin
      px_row = 0;
      px_col = 0;
    end
    blur_q.push_back(res);
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one request, with an occasional gap before it, and waits for its acceptance.
  task automatic send_req(in_item_t req);
    if (tx_bursty && !calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    if ($urandom_range(0, 149) == 0) tx_bursty = ~tx_bursty;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    blur_predict(req);
  endtask

  task automatic send_push(pixel_t p);
    in_item_t req;
    req.opcode   = OpPush;
    req.in_red   = p.red;
    req.in_green = p.green;
    req.in_blue  = p.blue;
    send_req(req);
  endtask

  task automatic send_push_rand();
    send_push({rand_chan(), rand_chan(), rand_chan()});
  endtask

  task automatic send_flush();
    in_item_t req;
    req.opcode   = OpFlush;
    req.in_red   = 8'($urandom);
    req.in_green = 8'($urandom);
    req.in_blue  = 8'($urandom);
    send_req(req);
  endtask

  // Stops offering requests and waits until every queued result has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgImageWidth) frame_w_reg = val[10:0];
    else frame_h_reg = val;
    px_row = 0;
    px_col = 0;
  endtask

  // Writes both size registers in random order; unused width bits carry noise.
  task automatic set_frame(logic [10:0] w, logic [15:0] h);
    logic [CfgDataW-1:0] w_data;
    w_data = {5'($urandom), w};
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CfgImageWidth, w_data);
      write_reg(CfgImageHeight, h);
    end else begin
      write_reg(CfgImageHeight, h);
      write_reg(CfgImageWidth, w_data);
    end
  endtask

  // Streams one frame of random pixels and flushes it out, with dropped
  // requests mixed in. A nonzero cut abandons the frame after that many pixels.
  task automatic run_frame(int unsigned cut);
    int unsigned k;
    k = 0;
    while (px_row < eff_h()) begin
      if (cut != 0 && k == cut) return;
      if ($urandom_range(0, 24) == 0) send_flush();
      send_push_rand();
      k++;
    end
    while (px_row >= eff_h()) begin
      if ($urandom_range(0, 19) == 0) send_push_rand();
      send_flush();
    end
  endtask

  // Corners, edges and center of a 3x3 frame, dropped requests, an abandoned
  // warm-up, then one-column and one-row frames.
  task automatic test_directed();
    pixel_t pat [9] = '{24'hFFFFFF, 24'h000000, 24'hFF0080, 24'h010203, 24'h807FFF,
                        24'h00FF00, 24'hAA5533, 24'hFE01C8, 24'h64C832};
    int i;
    write_reg(CfgImageWidth, 16'd3);
    write_reg(CfgImageHeight, 16'd3);
    send_flush();
    for (i = 0; i < 9; i++) send_push(pat[i]);
    send_push(pat[0]);
    while (px_row >= eff_h()) send_flush();
    // Start a new frame and drop it during warm-up with a register write.
    send_push(pat[3]);
    send_push(pat[6]);
    write_reg(CfgImageWidth, 16'd1);
    write_reg(CfgImageHeight, 16'd2);
    send_push(pat[2]);
    send_push(pat[7]);
    while (px_row >= eff_h()) send_flush();
    write_reg(CfgImageWidth, 16'd2);
    write_reg(CfgImageHeight, 16'd1);
    send_push(pat[5]);
    send_push(pat[8]);
    while (px_row >= eff_h()) send_flush();
  endtask

  // Register extremes: width with every bit set clamps to the line memory size,
  // tallest height, and zero for both.
  task automatic test_extremes();
    write_reg(CfgImageWidth, 16'hFFFF);
    write_reg(CfgImageHeight, 16'hFFFF);
    run_frame(MaxWidth + 4);
    write_reg(CfgImageWidth, 16'h0800);
    write_reg(CfgImageHeight, 16'h0000);
    run_frame(0);
  endtask

  // The receiver stops for a long stretch so the unit fills and stalls requests.
  task automatic test_backpressure();
    set_frame(11'd5, 16'd4);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    run_frame(0);
  endtask

  // Random frame sizes, mostly small, with back-to-back frames and abandoned ones.
  task automatic test_random();
    int unsigned base;
    int unsigned w;
    int unsigned h;
    int unsigned cut;
    bit          need_cfg;
    base = taken_cnt;
    need_cfg = 1'b1;
    while (taken_cnt < base + RandItems) begin
      if (taken_cnt >= base + RandItems * 4 / 5) calm = 1'b1;
      if (need_cfg || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: begin
            w = $urandom_range(0, 1);
            h = $urandom_range(1, 20);
          end
          1, 2: begin
            w = $urandom_range(9, 40);
            h = $urandom_range(1, 6);
          end
          3: begin
            w = $urandom_range(41, 160);
            h = $urandom_range(1, 3);
          end
          default: begin
            w = $urandom_range(2, 8);
            h = $urandom_range(0, 8);
          end
        endcase
        set_frame(11'(w), 16'(h));
      end
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 0;
      run_frame(cut);
      need_cfg = (px_row != 0 || px_col != 0);
    end
  endtask

  // Receiver: random stalls in bursts, quiet stretches, and the long hold.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) rx_bursty <= ~rx_bursty;
    if (rx_hold) begin
      out_ready_i <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall    <= rx_stall - 1;
      out_ready_i <= 1'b0;
    end else if (rx_bursty && !calm && $urandom_range(0, 7) == 0) begin
      rx_stall    <= $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each accepted result with the oldest expected pixel.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blur_q.size() == 0) begin
        err_cnt++;
        $display("%0t: expected no result, actual %h", $time, out_data_o);
      end else begin
        want = blur_q.pop_front();
        check_field("out_red", want.out_red, out_data_o.out_red);
        check_field("out_green", want.out_green, out_data_o.out_green);
        check_field("out_blue", want.out_blue, out_data_o.out_blue);
        check_field("out_last", 8'(want.out_last), 8'(out_data_o.out_last));
      end
    end
  end

  initial begin
    frame_w_reg = 11'd1024;
    frame_h_reg = 16'd1;
    px_row = 0;
    px_col = 0;
    foreach (row_above[i]) begin
      row_above[i]  = '0;
      row_above2[i] = '0;
    end
    foreach (blur_win[i]) blur_win[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extremes();
    test_backpressure();
    test_random();
    drain();
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
